// ===== design/swc_pkg.sv =====
// shared types and defaults of the source whitespace compactor
package swc_pkg;

  // default number of entries between classifier and emitter
  localparam int unsigned QueueDepthDefault = 4;

  // one classified input byte: one or two output bytes
  typedef struct packed {
    logic       second_valid;
    logic [7:0] first_char;
    logic [7:0] second_char;
  } swc_entry_t;

  // push request from the classifier into the queue
  typedef struct packed {
    logic       valid;
    swc_entry_t entry;
  } swc_push_t;

  // head of the queue as seen by the emitter
  typedef struct packed {
    logic       valid;
    swc_entry_t entry;
  } swc_head_t;

endpackage

// ===== design/source_whitespace_compactor.sv =====
// top level of the source whitespace compactor
//
// Usage: source text enters one byte per request on the s_axis channel, a
// newline (10) ending each line. Compacted text leaves on the m_axis channel,
// one byte per request; tlast marks the final output byte caused by one input
// byte (an input byte causes zero, one or two output bytes).
// The cfg channel writes strip_comments (bit 0); it is always ready and must
// only be written while the block is idle. Reset sets strip_comments to 1.
// An accepted byte goes into the queue, then out through the output register.
// Throughput: one input byte per cycle while the queue has room, bounded by
// the output register at one output byte per cycle while the receiver is
// ready. The classifier and the emitter are parted by a queue of QueueDepth
// entries; the classifier keeps taking input while the receiver stalls until
// that queue is full, then drops s_axis_tready_o.
// Reset (rst_ni low, asynchronous) empties the queue and output register and
// returns the line state to the start of a line outside any string.
module source_whitespace_compactor #(
  parameter int unsigned QueueDepth = swc_pkg::QueueDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] in_char
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_char
  output logic       m_axis_tlast_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [0:0] cfg_data_i        // [0] strip_comments
);

  swc_pkg::swc_push_t push;
  swc_pkg::swc_head_t head;
  logic               q_ready;
  logic               pop;

  assign cfg_ready_o = 1'b1;

  // classifier
  swc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_char_i   (s_axis_tdata_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i[0]),
    .q_ready_i   (q_ready),
    .push_o      (push)
  );

  // queue between the two halves
  swc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .ready_o (q_ready),
    .head_o  (head),
    .pop_i   (pop)
  );

  // emitter
  swc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_char_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o)
  );

endmodule

// ===== design/swc_front.sv =====
// classifier: line, quote, space and comment state, one input byte per cycle while the queue is not full
module swc_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       in_char_i,
  input  logic             cfg_valid_i,
  input  logic             cfg_data_i,
  input  logic             q_ready_i,
  output swc_pkg::swc_push_t push_o
);

  localparam logic [7:0] CharNewline = 8'd10;
  localparam logic [7:0] CharSpace   = 8'h20;
  localparam logic [7:0] CharSquote  = 8'd39;
  localparam logic [7:0] CharDquote  = 8'd34;
  localparam logic [7:0] CharSlash   = 8'h2f;
  localparam logic [7:0] CharPercent = 8'h25;
  localparam logic [7:0] CharAmp     = 8'h26;
  localparam logic [7:0] CharUnder   = 8'h5f;

  function automatic logic is_ident(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a) ||
           (c >= 8'h30 && c <= 8'h39) || c == CharUnder;
  endfunction

  function automatic logic is_right_keep(input logic [7:0] c);
    return is_ident(c) || c == CharPercent || c == CharAmp || c == CharSquote;
  endfunction

  logic       strip_q;
  logic       quote_open_q, quote_open_d;
  logic [7:0] quote_kind_q, quote_kind_d;
  logic       in_indent_q, in_indent_d;
  logic       col_zero_q, col_zero_d;
  logic [1:0] space_run_q, space_run_d;
  logic [7:0] prev_vis_q, prev_vis_d;
  logic       slash_held_q, slash_held_d;
  logic       comment_skip_q, comment_skip_d;
  logic       line_dropped_q, line_dropped_d;

  logic [7:0] out_chars [2];
  logic [1:0] out_cnt;
  logic       accept;

  assign in_ready_o = q_ready_i;
  assign accept     = in_valid_i && q_ready_i;

  // next state and produced bytes for the byte on the input
  always_comb begin
    logic done;
    done           = 1'b0;
    out_chars[0]   = 8'h00;
    out_chars[1]   = 8'h00;
    out_cnt        = 2'd0;
    quote_open_d   = quote_open_q;
    quote_kind_d   = quote_kind_q;
    in_indent_d    = in_indent_q;
    col_zero_d     = col_zero_q;
    space_run_d    = space_run_q;
    prev_vis_d     = prev_vis_q;
    slash_held_d   = slash_held_q;
    comment_skip_d = comment_skip_q;
    line_dropped_d = line_dropped_q;
    if (comment_skip_q) begin
      if (in_char_i == CharNewline) begin
        if (!line_dropped_q) begin
          out_chars[out_cnt[0]] = CharNewline;
          out_cnt = out_cnt + 2'd1;
        end
        quote_open_d   = 1'b0;
        in_indent_d    = 1'b1;
        col_zero_d     = 1'b1;
        space_run_d    = 2'd0;
        prev_vis_d     = 8'h00;
        slash_held_d   = 1'b0;
        comment_skip_d = 1'b0;
        line_dropped_d = 1'b0;
      end
    end else if (quote_open_q) begin
      out_chars[out_cnt[0]] = in_char_i;
      out_cnt = out_cnt + 2'd1;
      if (in_char_i == CharNewline) begin
        quote_open_d   = 1'b0;
        in_indent_d    = 1'b1;
        space_run_d    = 2'd0;
        prev_vis_d     = 8'h00;
        slash_held_d   = 1'b0;
        comment_skip_d = 1'b0;
        line_dropped_d = 1'b0;
      end else if (in_char_i == quote_kind_q) begin
        quote_open_d = 1'b0;
        prev_vis_d   = in_char_i;
      end
      // cleared even right after a newline inside quotes
      col_zero_d = 1'b0;
    end else begin
      // held slash decides first
      if (slash_held_q) begin
        slash_held_d = 1'b0;
        if (in_char_i == CharSlash && strip_q) begin
          comment_skip_d = 1'b1;
          line_dropped_d = col_zero_q;
          col_zero_d     = 1'b0;
          done           = 1'b1;
        end else begin
          out_chars[out_cnt[0]] = CharSlash;
          out_cnt    = out_cnt + 2'd1;
          col_zero_d = 1'b0;
        end
      end
      if (!done) begin
        if (in_char_i == CharNewline) begin
          if (space_run_q == 2'd2) begin
            out_chars[out_cnt[0]] = CharSpace;
            out_cnt = out_cnt + 2'd1;
          end
          out_chars[out_cnt[0]] = CharNewline;
          out_cnt        = out_cnt + 2'd1;
          quote_open_d   = 1'b0;
          in_indent_d    = 1'b1;
          col_zero_d     = 1'b1;
          space_run_d    = 2'd0;
          prev_vis_d     = 8'h00;
          slash_held_d   = 1'b0;
          comment_skip_d = 1'b0;
          line_dropped_d = 1'b0;
        end else if (in_char_i == CharSpace) begin
          if (in_indent_q) begin
            out_chars[out_cnt[0]] = CharSpace;
            out_cnt = out_cnt + 2'd1;
          end else if (space_run_q != 2'd2) begin
            space_run_d = space_run_q + 2'd1;
          end
          col_zero_d = 1'b0;
        end else begin
          in_indent_d = 1'b0;
          if (space_run_q == 2'd2 ||
              (space_run_q == 2'd1 && is_ident(prev_vis_q) && is_right_keep(in_char_i)))
          begin
            out_chars[out_cnt[0]] = CharSpace;
            out_cnt = out_cnt + 2'd1;
          end
          space_run_d = 2'd0;
          prev_vis_d  = in_char_i;
          if (in_char_i == CharSlash && strip_q) begin
            slash_held_d = 1'b1;
          end else begin
            out_chars[out_cnt[0]] = in_char_i;
            out_cnt    = out_cnt + 2'd1;
            col_zero_d = 1'b0;
            if (in_char_i == CharSquote || in_char_i == CharDquote) begin
              quote_open_d = 1'b1;
              quote_kind_d = in_char_i;
            end
          end
        end
      end
    end
  end

  // push request toward the queue
  always_comb begin
    push_o.valid              = accept && (out_cnt != 2'd0);
    push_o.entry.first_char   = out_chars[0];
    push_o.entry.second_char  = out_chars[1];
    push_o.entry.second_valid = out_cnt[1];
  end

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strip_q <= 1'b1;
    end else if (cfg_valid_i) begin
      strip_q <= cfg_data_i;
    end
  end

  // line state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quote_open_q   <= 1'b0;
      quote_kind_q   <= 8'h00;
      in_indent_q    <= 1'b1;
      col_zero_q     <= 1'b1;
      space_run_q    <= 2'd0;
      prev_vis_q     <= 8'h00;
      slash_held_q   <= 1'b0;
      comment_skip_q <= 1'b0;
      line_dropped_q <= 1'b0;
    end else if (accept) begin
      quote_open_q   <= quote_open_d;
      quote_kind_q   <= quote_kind_d;
      in_indent_q    <= in_indent_d;
      col_zero_q     <= col_zero_d;
      space_run_q    <= space_run_d;
      prev_vis_q     <= prev_vis_d;
      slash_held_q   <= slash_held_d;
      comment_skip_q <= comment_skip_d;
      line_dropped_q <= line_dropped_d;
    end
  end

`ifndef SYNTH
  // a comment never starts inside a string
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(comment_skip_q && quote_open_q))
    else $error("comment and quote both active");

  // a slash is never held once a comment runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(comment_skip_q && slash_held_q))
    else $error("slash held inside comment");
`endif

endmodule

// ===== design/swc_queue.sv =====
// short queue of classified entries between classifier and emitter
module swc_queue #(
  parameter int unsigned Depth = swc_pkg::QueueDepthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  swc_pkg::swc_push_t push_i,
  output logic               ready_o,
  output swc_pkg::swc_head_t head_o,
  input  logic               pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  swc_pkg::swc_entry_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign ready_o     = (count_q != CntW'(Depth));
  assign do_push     = push_i.valid && ready_o;
  assign do_pop      = pop_i && (count_q != '0);
  assign head_o.valid = (count_q != '0);
  assign head_o.entry = mem_q[rd_ptr_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

`ifndef SYNTH
  // fill count stays within the storage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue overfilled");
`endif

endmodule

// ===== design/swc_back.sv =====
// emitter: one output byte per cycle from the queue head into the output register, while the receiver is ready
module swc_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  swc_pkg::swc_head_t head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         out_char_o,
  output logic               out_last_o
);

  logic       valid_q, valid_d;
  logic [7:0] char_q, char_d;
  logic       last_q, last_d;
  logic       phase_q, phase_d;
  logic       load;

  assign load        = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_char_o  = char_q;
  assign out_last_o  = last_q;

  // pick the next byte of the head entry
  always_comb begin
    valid_d = valid_q;
    char_d  = char_q;
    last_d  = last_q;
    phase_d = phase_q;
    pop_o   = 1'b0;
    if (load) begin
      valid_d = head_i.valid;
      if (head_i.valid) begin
        if (phase_q) begin
          char_d  = head_i.entry.second_char;
          last_d  = 1'b1;
          phase_d = 1'b0;
          pop_o   = 1'b1;
        end else begin
          char_d  = head_i.entry.first_char;
          last_d  = !head_i.entry.second_valid;
          phase_d = head_i.entry.second_valid;
          pop_o   = !head_i.entry.second_valid;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    last_q <= last_d;
  end

`ifndef SYNTH
  // second byte pending means its entry is still at the head
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> head_i.valid)
    else $error("second byte pending without entry");
`endif

endmodule

// ===== test/source_whitespace_compactor_tb.sv =====
// self-checking testbench for the source whitespace compactor
module source_whitespace_compactor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // character codes the compactor cares about
  localparam logic [7:0] NEWLINE    = 8'd10;
  localparam logic [7:0] SPACE      = 8'd32;
  localparam logic [7:0] DQUOTE     = 8'd34;
  localparam logic [7:0] SQUOTE     = 8'd39;
  localparam logic [7:0] SLASH      = 8'd47;
  localparam logic [7:0] UNDERSCORE = 8'd95;

  localparam int IDLE_PCT    = 22;
  localparam int SETTLE      = 8;
  localparam int STALL_LIMIT = 1000;
  localparam int PHASE_BYTES = 180;

  typedef struct packed {
    logic [7:0] ch;
    logic       is_last;
  } out_byte_t;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       byte_valid = 1'b0;
  logic [7:0] byte_data = '0;
  logic       out_ready = 1'b0;
  logic       cfg_valid = 1'b0;
  logic [0:0] cfg_data = '0;
  logic       s_ready;
  logic       m_valid;
  logic [7:0] m_data;
  logic       m_last;
  logic       cfg_ready;

  bit         failed = 1'b0;
  bit         calm = 1'b0;
  int         stuck = 0;
  string      punct_pool = "%&;(){}=+*,.!#<>-'\"/";

  logic [7:0] pending_q[$];
  out_byte_t  expected_q[$];

  // predictor state
  logic       strip_on;
  logic       quote_open;
  logic [7:0] quote_ch;
  logic       indent;
  logic       col0;
  logic [1:0] spaces;
  logic [7:0] last_vis;
  logic       slash_wait;
  logic       skipping;
  logic       drop_line;

  source_whitespace_compactor dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (byte_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (byte_data),   // [7:0] in_char
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (out_ready),
    .m_axis_tdata_o  (m_data),      // [7:0] out_char
    .m_axis_tlast_o  (m_last),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_data_i      (cfg_data)     // [0] strip_comments
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit ident_char(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
           (c >= "0" && c <= "9") || c == UNDERSCORE;
  endfunction

  function automatic bit right_keep(input logic [7:0] c);
    return ident_char(c) || c == "%" || c == "&" || c == SQUOTE;
  endfunction

  task automatic start_line();
    quote_open = 1'b0;
    indent     = 1'b1;
    col0       = 1'b1;
    spaces     = '0;
    last_vis   = '0;
    slash_wait = 1'b0;
    skipping   = 1'b0;
    drop_line  = 1'b0;
  endtask

  // expected output bytes for one accepted input byte
  task automatic compact_byte(input logic [7:0] c);
    logic [7:0] outs[$];
    bit taken;
    taken = 1'b0;
    if (skipping) begin
      if (c == NEWLINE) begin
        if (!drop_line) outs.push_back(NEWLINE);
        start_line();
      end
    end else if (quote_open) begin
      outs.push_back(c);
      if (c == NEWLINE) begin
        start_line();
      end else if (c == quote_ch) begin
        quote_open = 1'b0;
        last_vis   = c;
      end
      col0 = 1'b0;
    end else begin
      // a held slash is settled by this byte
      if (slash_wait) begin
        slash_wait = 1'b0;
        if (c == SLASH && strip_on) begin
          skipping  = 1'b1;
          drop_line = col0;
          col0      = 1'b0;
          taken     = 1'b1;
        end else begin
          outs.push_back(SLASH);
          col0 = 1'b0;
        end
      end
      if (!taken) begin
        if (c == NEWLINE) begin
          if (spaces >= 2) outs.push_back(SPACE);
          outs.push_back(NEWLINE);
          start_line();
        end else if (c == SPACE) begin
          if (indent) outs.push_back(SPACE);
          else if (spaces < 2) spaces++;
          col0 = 1'b0;
        end else begin
          indent = 1'b0;
          if (spaces >= 2 || (spaces == 1 && ident_char(last_vis) && right_keep(c)))
            outs.push_back(SPACE);
          spaces   = '0;
          last_vis = c;
          if (c == SLASH && strip_on) begin
            slash_wait = 1'b1;
          end else begin
            outs.push_back(c);
            col0 = 1'b0;
            if (c == SQUOTE || c == DQUOTE) begin
              quote_open = 1'b1;
              quote_ch   = c;
            end
          end
        end
      end
    end
    foreach (outs[k]) expected_q.push_back('{ch: outs[k], is_last: (k == outs.size() - 1)});
  endtask

  // input byte driver
  always @(posedge clk) begin
    if (!rst_n) begin
      byte_valid <= 1'b0;
    end else if (!byte_valid || s_ready) begin
      if (pending_q.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
        byte_valid <= 1'b1;
        byte_data  <= pending_q.pop_front();
      end else begin
        byte_valid <= 1'b0;
      end
    end
  end

  // output monitor, prediction on accepted requests and progress watchdog
  always @(posedge clk) begin
    out_byte_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      if (m_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected output, actual char %02h last %0b", $time, m_data, m_last);
          failed = 1'b1;
        end else begin
          want = expected_q.pop_front();
          if (want.ch !== m_data || want.is_last !== m_last) begin
            $display("%0t: mismatch, expected char %02h last %0b, actual char %02h last %0b",
                     $time, want.ch, want.is_last, m_data, m_last);
            failed = 1'b1;
          end
        end
      end
      if (cfg_valid && cfg_ready) strip_on = cfg_data[0];
      if (byte_valid && s_ready) compact_byte(byte_data);
      // watchdog on cycles without any accepted request
      if ((m_valid && out_ready) || (byte_valid && s_ready) || (cfg_valid && cfg_ready)) begin
        stuck = 0;
      end else begin
        stuck++;
        if (stuck >= STALL_LIMIT) begin
          $display("%0t: no progress, %0d output bytes still expected", $time,
                   expected_q.size());
          $display("TEST FAILED");
          $finish;
        end
      end
    end
  end

  task automatic write_strip(input logic value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    // ready seen ahead of the edge that takes the write
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (pending_q.size() != 0 || byte_valid || expected_q.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) pending_q.push_back(s[i]);
  endtask

  function automatic logic [7:0] rand_ident();
    case ($urandom_range(0, 3))
      0: return 8'($urandom_range(97, 122));
      1: return 8'($urandom_range(65, 90));
      2: return 8'($urandom_range(48, 57));
      default: return UNDERSCORE;
    endcase
  endfunction

  // one source token with random content
  task automatic queue_token();
    logic [7:0] q;
    case ($urandom_range(0, 9))
      0, 1, 2: repeat ($urandom_range(1, 5)) pending_q.push_back(rand_ident());
      3, 4: repeat ($urandom_range(1, 3)) pending_q.push_back(SPACE);
      5: pending_q.push_back(punct_pool[$urandom_range(0, punct_pool.len() - 1)]);
      6: begin
        q = $urandom_range(0, 1) ? SQUOTE : DQUOTE;
        pending_q.push_back(q);
        repeat ($urandom_range(0, 5)) begin
          case ($urandom_range(0, 3))
            0: pending_q.push_back(rand_ident());
            1: pending_q.push_back(SPACE);
            2: pending_q.push_back(SLASH);
            default: pending_q.push_back(8'($urandom_range(0, 255)));
          endcase
        end
        if ($urandom_range(0, 4) != 0) pending_q.push_back(q);
      end
      7: repeat ($urandom_range(1, 2)) pending_q.push_back(SLASH);
      8: pending_q.push_back(8'($urandom_range(0, 255)));
      default: pending_q.push_back(NEWLINE);
    endcase
  endtask

  // mostly well-formed lines, some pure noise
  task automatic queue_line();
    if ($urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 10)) pending_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(0, 3)) pending_q.push_back(SPACE);
      if ($urandom_range(0, 7) == 0) queue_text("//");
      repeat ($urandom_range(1, 8)) queue_token();
    end
    pending_q.push_back(NEWLINE);
  endtask

  initial begin
    strip_on = 1'b1;
    quote_ch = '0;
    start_line();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: dropped comment line, quote at line start left open,
    // kept and dropped spaces, held slash at end of line, byte extremes,
    // trailing space run, mid-line comment, empty line
    queue_text("//c\n");
    queue_text("\"q\n");
    queue_text("_ %  /\n");
    pending_q.push_back(8'd0);
    pending_q.push_back(8'd255);
    pending_q.push_back(SPACE);
    pending_q.push_back(8'd128);
    pending_q.push_back(SPACE);
    pending_q.push_back(SPACE);
    pending_q.push_back(NEWLINE);
    queue_text("x //\n");
    pending_q.push_back(NEWLINE);
    wait_drained();

    // random phases over both register settings, one without any idling
    for (int ph = 0; ph < 4; ph++) begin
      write_strip(ph[0]);
      @(negedge clk);
      calm = (ph == 2);
      while (pending_q.size() < PHASE_BYTES) queue_line();
      wait_drained();
    end

    if (!failed) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
